// File: hw/rtl/ilre_pkg.sv
// Shared types and constants for the index line record extractor.
// Holds the request payload structs, status codes and register indexes.
// No dependencies.
package ilre_pkg;

  localparam int OFF_BITS   = 48;
  localparam int DELIM_BITS = 16;
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = OFF_BITS;

  localparam logic [7:0] CHAR_NEWLINE = 8'd10;
  localparam logic [7:0] CHAR_COMMA   = 8'd44;
  localparam logic [7:0] CHAR_ZERO    = 8'd48;
  localparam logic [7:0] CHAR_NINE    = 8'd57;
  localparam logic [3:0] RADIX        = 4'd10;

  localparam logic [CFG_IDX_W-1:0] REG_SEP_LEN      = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DATA_BASE    = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DATA_SPACE   = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_RECORD_LIMIT = 8'd3;

  typedef enum logic [1:0] {
    ST_RECORD    = 2'd0,
    ST_NO_SPACE  = 2'd1,
    ST_MALFORMED = 2'd2
  } status_t;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       stream_end;
  } in_item_t;

  typedef struct packed {
    logic [OFF_BITS-1:0] record_offset;
    logic [OFF_BITS-1:0] record_length;
    status_t             status;
    logic                final_res;
  } out_item_t;

  // Summary of the current line after the byte being processed.
  typedef struct packed {
    logic [1:0]          commas;
    logic                prior_bad;
    logic [OFF_BITS-1:0] prior_value;
  } line_info_t;

endpackage

// File: hw/rtl/ilre_line_parser.sv
// Per-line field parser: decimal accumulation with saturation and comma tracking.
// Depends on ilre_pkg.
module ilre_line_parser import ilre_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       step_en,
  input  logic       line_close,
  input  in_item_t   item,
  output line_info_t line_nxt
);

  localparam int PROD_W = OFF_BITS + 4;

  logic [OFF_BITS-1:0] field_value_r, field_value_nxt;
  logic                field_bad_r, field_bad_nxt;
  logic [OFF_BITS-1:0] prior_value_r, prior_value_nxt;
  logic                prior_bad_r, prior_bad_nxt;
  logic [1:0]          comma_seen_r, comma_seen_nxt;

  logic [PROD_W-1:0] ext_val;
  logic [PROD_W-1:0] prod;
  logic [3:0]        digit;
  logic              is_digit;

  assign digit    = 4'(item.text_byte - CHAR_ZERO);
  assign is_digit = (item.text_byte >= CHAR_ZERO) && (item.text_byte <= CHAR_NINE);
  assign ext_val  = PROD_W'(field_value_r);
  // Ten times the value as two shifts, plus the new digit.
  assign prod     = (ext_val << 3) + (ext_val << 1) + PROD_W'(digit);

  always_comb begin
    field_value_nxt = field_value_r;
    field_bad_nxt   = field_bad_r;
    prior_value_nxt = prior_value_r;
    prior_bad_nxt   = prior_bad_r;
    comma_seen_nxt  = comma_seen_r;
    if (item.text_byte == CHAR_COMMA) begin
      prior_value_nxt = field_value_r;
      prior_bad_nxt   = field_bad_r;
      field_value_nxt = '0;
      field_bad_nxt   = 1'b0;
      if (comma_seen_r != 2'd2) begin
        comma_seen_nxt = comma_seen_r + 2'd1;
      end
    end else if (is_digit) begin
      if (|prod[PROD_W-1:OFF_BITS]) begin
        field_value_nxt = '1;
      end else begin
        field_value_nxt = prod[OFF_BITS-1:0];
      end
    end else if (item.text_byte != CHAR_NEWLINE) begin
      field_bad_nxt = 1'b1;
    end
  end

  assign line_nxt.commas      = comma_seen_nxt;
  assign line_nxt.prior_bad   = prior_bad_nxt;
  assign line_nxt.prior_value = prior_value_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      field_value_r <= '0;
      field_bad_r   <= 1'b0;
      prior_value_r <= '0;
      prior_bad_r   <= 1'b0;
      comma_seen_r  <= 2'd0;
    end else if (step_en) begin
      if (line_close) begin
        field_value_r <= '0;
        field_bad_r   <= 1'b0;
        prior_value_r <= '0;
        prior_bad_r   <= 1'b0;
        comma_seen_r  <= 2'd0;
      end else begin
        field_value_r <= field_value_nxt;
        field_bad_r   <= field_bad_nxt;
        prior_value_r <= prior_value_nxt;
        prior_bad_r   <= prior_bad_nxt;
        comma_seen_r  <= comma_seen_nxt;
      end
    end
  end

endmodule

// File: hw/rtl/ilre_record_unit.sv
// Record bookkeeping: data space check, record count, halt flag, result build.
// Depends on ilre_pkg.
module ilre_record_unit import ilre_pkg::*; #(
  parameter int COUNT_BITS = 24
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  step_valid,
  input  in_item_t              item,
  input  line_info_t            line_nxt,
  input  logic [DELIM_BITS-1:0] sep_len,
  input  logic [OFF_BITS-1:0]   data_base,
  input  logic [OFF_BITS-1:0]   data_space,
  input  logic [COUNT_BITS-1:0] record_limit,
  output logic                  parse_en,
  output logic                  line_close,
  output logic                  res_valid,
  output out_item_t             res_item
);

  localparam int SUM_W = OFF_BITS + 2;

  logic [OFF_BITS-1:0]   data_used_r, data_used_nxt;
  logic [COUNT_BITS-1:0] records_done_r, records_done_nxt;
  logic                  halted_r, halted_nxt;

  logic             active, limit_hit, malformed, over;
  logic [SUM_W-1:0] need, total;

  assign active     = step_valid && !halted_r;
  assign limit_hit  = records_done_r >= record_limit;
  assign parse_en   = active && !limit_hit;
  assign line_close = parse_en && ((item.text_byte == CHAR_NEWLINE) || item.stream_end);

  assign malformed = (line_nxt.commas != 2'd2) || line_nxt.prior_bad;
  assign need      = SUM_W'(line_nxt.prior_value) + SUM_W'(sep_len);
  assign total     = SUM_W'(data_used_r) + need;
  // The extra top bits make a carry out of the offset range count as exceeding.
  assign over      = total > SUM_W'(data_space);

  always_comb begin
    data_used_nxt           = data_used_r;
    records_done_nxt        = records_done_r;
    halted_nxt              = halted_r;
    res_valid               = 1'b0;
    res_item.record_offset  = '0;
    res_item.record_length  = '0;
    res_item.status         = ST_RECORD;
    res_item.final_res      = 1'b1;
    if (active && limit_hit) begin
      halted_nxt = 1'b1;
    end else if (line_close) begin
      res_valid = 1'b1;
      if (malformed) begin
        halted_nxt      = 1'b1;
        res_item.status = ST_MALFORMED;
      end else if (over) begin
        halted_nxt      = 1'b1;
        res_item.status = ST_NO_SPACE;
      end else begin
        res_item.record_offset = data_base + data_used_r;
        res_item.record_length = line_nxt.prior_value;
        data_used_nxt          = total[OFF_BITS-1:0];
        records_done_nxt       = records_done_r + COUNT_BITS'(1);
        if (item.stream_end || (records_done_nxt >= record_limit)) begin
          halted_nxt         = 1'b1;
          res_item.final_res = 1'b1;
        end else begin
          res_item.final_res = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      data_used_r    <= '0;
      records_done_r <= '0;
      halted_r       <= 1'b0;
    end else begin
      data_used_r    <= data_used_nxt;
      records_done_r <= records_done_nxt;
      halted_r       <= halted_nxt;
    end
  end

endmodule

// File: hw/rtl/ilre_out_queue.sv
// Two-entry result queue that lets the parser keep running while a result waits.
// Depends on ilre_pkg.
module ilre_out_queue import ilre_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      wr_en,
  input  out_item_t wr_item,
  output logic      full,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  out_item_t  ent_r [2];
  logic       wptr_r, rptr_r;
  logic [1:0] cnt_r, cnt_nxt;
  logic       rd_en;

  assign full      = cnt_r == 2'd2;
  assign out_valid = cnt_r != 2'd0;
  assign out_data  = ent_r[rptr_r];
  assign rd_en     = out_valid && out_ready;

  always_comb begin
    cnt_nxt = cnt_r;
    if (wr_en && !rd_en) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (rd_en && !wr_en) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      ent_r[wptr_r] <= wr_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= 1'b0;
      rptr_r <= 1'b0;
      cnt_r  <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
      if (wr_en) begin
        wptr_r <= !wptr_r;
      end
      if (rd_en) begin
        rptr_r <= !rptr_r;
      end
    end
  end

endmodule

// File: hw/rtl/index_line_record_extractor_top.sv
// Index line record extractor, top level.
// Input channel: one index text byte per request (in_data.text_byte, in_data.stream_end).
// Output channel: one record request per closed line (offset, length, status, final_res).
// Config channel: cfg_index 0..3 selects the delimiter length, data base, data space and
// record limit; other indexes are ignored. cfg_ready is always high; write only while idle.
// An accepted byte is held in the input register, is parsed and, on a newline or stream
// end, its result enters a two-entry output queue. out_valid is driven by the queue, so a
// result passes through the input register and a queue entry before it can be taken.
// The input takes one byte per cycle while the output queue is not full; the digit
// accumulate and the data-space add and compare are combinational.
// When the receiver stalls the queue fills; with two results waiting the input register
// holds its byte and in_ready stays low until the cycle after a result is taken.
// Synchronous reset (rst_n low) clears the config registers, input valid flag, queue
// pointers, line state, counters and the halt flag. Once halted (error, record limit or
// stream end) bytes are taken and dropped until the next reset.
// Depends on ilre_pkg, ilre_line_parser, ilre_record_unit, ilre_out_queue.
module index_line_record_extractor_top import ilre_pkg::*; #(
  parameter int COUNT_BITS = 24
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  in_item_t              in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output out_item_t             out_data,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  logic [DELIM_BITS-1:0] sep_len_r;
  logic [OFF_BITS-1:0]   data_base_r, data_space_r;
  logic [COUNT_BITS-1:0] record_limit_r;

  in_item_t   in_item_r;
  logic       in_valid_r;
  logic       advance, q_full;
  logic       parse_en, line_close, res_valid;
  out_item_t  res_item;
  line_info_t line_nxt;

  assign cfg_ready = 1'b1;
  assign advance   = in_valid_r && !q_full;
  assign in_ready  = !in_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sep_len_r      <= '0;
      data_base_r    <= '0;
      data_space_r   <= '0;
      record_limit_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_SEP_LEN:      sep_len_r      <= cfg_data[DELIM_BITS-1:0];
        REG_DATA_BASE:    data_base_r    <= cfg_data[OFF_BITS-1:0];
        REG_DATA_SPACE:   data_space_r   <= cfg_data[OFF_BITS-1:0];
        REG_RECORD_LIMIT: record_limit_r <= cfg_data[COUNT_BITS-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_item_r <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ready) begin
      in_valid_r <= in_valid;
    end
  end

  ilre_line_parser u_parser (
    .clk        (clk),
    .rst_n      (rst_n),
    .step_en    (parse_en),
    .line_close (line_close),
    .item       (in_item_r),
    .line_nxt   (line_nxt)
  );

  ilre_record_unit #(
    .COUNT_BITS (COUNT_BITS)
  ) u_record (
    .clk          (clk),
    .rst_n        (rst_n),
    .step_valid   (advance),
    .item         (in_item_r),
    .line_nxt     (line_nxt),
    .sep_len      (sep_len_r),
    .data_base    (data_base_r),
    .data_space   (data_space_r),
    .record_limit (record_limit_r),
    .parse_en     (parse_en),
    .line_close   (line_close),
    .res_valid    (res_valid),
    .res_item     (res_item)
  );

  ilre_out_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .wr_en     (res_valid),
    .wr_item   (res_item),
    .full      (q_full),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

// File: hw/rtl/ilre_checker.sv
// Port-level checks for the index line record extractor, bound to the top level.
// Depends on ilre_pkg and index_line_record_extractor_top.
module ilre_checker import ilre_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  input logic      out_valid,
  input logic      out_ready,
  input out_item_t out_data
);

  // A stalled result request keeps its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled result changed or dropped");

  // Error results carry no offset or length and always end the run.
  a_err_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.status != ST_RECORD) |->
      out_data.final_res && (out_data.record_offset == '0) &&
      (out_data.record_length == '0))
    else $error("error result with payload or without final flag");

  // Nothing follows the final result.
  a_final_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && out_data.final_res |=> !out_valid)
    else $error("result after final result");

  // Reset empties the result queue.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result present after reset");

endmodule

bind index_line_record_extractor_top ilre_checker u_ilre_checker (.*);
